@@ rtl/swm_pkg.sv @@
// Shared types, constants and helpers for the sliding window median block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package swm_pkg;

   // Sizing of the window and the data path
   localparam int MAX_WINDOW   = 32;
   localparam int SAMPLE_WIDTH = 32;
   localparam int OUT_WIDTH    = SAMPLE_WIDTH + 1;
   localparam int CSR_WIDTH    = 6;
   localparam int IDX_WIDTH    = $clog2(MAX_WINDOW);
   localparam int AGE_WIDTH    = IDX_WIDTH;
   localparam int CNT_WIDTH    = IDX_WIDTH + 1;
   localparam logic [CSR_WIDTH-1:0] WINDOW_RESET = CSR_WIDTH'(3);

   // One slot of the sorted chain
   typedef struct packed {
      logic                    valid;
      logic [SAMPLE_WIDTH-1:0] value;
      logic [AGE_WIDTH-1:0]    age;
   } cell_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic                    step;    // chain updates this cycle
      logic                    ins;     // a new sample is inserted
      logic [SAMPLE_WIDTH-1:0] sample;
      logic [CNT_WIDTH-1:0]    win;     // effective window length
   } cell_ctrl_type;

   // Clamp the raw register to 1..MAX_WINDOW
   function automatic logic [CNT_WIDTH-1:0] eff_window(input logic [CSR_WIDTH-1:0] raw);
      int r;
      r = int'(raw);
      if (r == 0) begin
         r = 1;
      end else if (r > MAX_WINDOW) begin
         r = MAX_WINDOW;
      end
      return CNT_WIDTH'(r);
   endfunction

endpackage

@@ rtl/swm_stream_if.sv @@
// Valid/ready channel interfaces for the sample and result streams.
// Depends on swm_pkg for the payload widths.
`timescale 1ns / 1ps

interface swm_req_if import swm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_WIDTH-1:0] median_doubled;

   modport source (output valid, output median_doubled, input ready);
   modport sink   (input valid, input median_doubled, output ready);
endinterface

@@ rtl/swm_cell.sv @@
// One slot of the sorted window chain: holds a value and its age, and
// per update drops out, shifts toward a neighbor or takes the new sample.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_type      left_cell,
   input  logic          left_le,
   input  logic          left_past,
   input  cell_type      right_cell,
   input  logic          right_le,
   output cell_type      cell_q,
   output logic          le,
   output logic          evict,
   output logic          past
);

   cell_type cell_ff;
   cell_type cell_in;
   cell_type r_self;
   cell_type r_left;
   logic     r_self_le;
   logic     r_left_le;

   // Local flags: value not above the sample, and too old for the window
   always_comb begin
      le    = cell_ff.valid && ($signed(cell_ff.value) <= $signed(ctrl.sample));
      evict = cell_ff.valid &&
              ((CNT_WIDTH'(cell_ff.age) + CNT_WIDTH'(1)) >= ctrl.win);
      past  = left_past | evict;
   end

   // Chain after the lowest stale slot is removed, seen at this slot and left of it
   always_comb begin
      r_self    = past      ? right_cell : cell_ff;
      r_self_le = past      ? right_le   : le;
      r_left    = left_past ? cell_ff    : left_cell;
      r_left_le = left_past ? le         : left_le;
   end

   // Sorted insert: keep, take the sample, or take the left neighbor
   always_comb begin
      cell_in = r_self;
      if (ctrl.ins) begin
         if (r_self_le) begin
            cell_in     = r_self;
            cell_in.age = r_self.age + AGE_WIDTH'(1);
         end else if (r_left_le) begin
            cell_in.valid = 1'b1;
            cell_in.value = ctrl.sample;
            cell_in.age   = '0;
         end else begin
            cell_in     = r_left;
            cell_in.age = r_left.age + AGE_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (ctrl.step) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;

endmodule

@@ rtl/swm_median_out.sv @@
// Picks the middle slot(s) of the sorted chain, adds them and holds the
// result beat in the output register. Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_median_out import swm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_type             cells [MAX_WINDOW],
   input  logic [CNT_WIDTH-1:0] win,
   input  logic                 fire,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [OUT_WIDTH-1:0] median_doubled,
   output logic                 hold
);

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [OUT_WIDTH-1:0]    median_ff;
   logic [OUT_WIDTH-1:0]    median_in;
   logic [IDX_WIDTH-1:0]    lo_idx;
   logic [IDX_WIDTH-1:0]    hi_idx;
   logic [SAMPLE_WIDTH-1:0] lo_val;
   logic [SAMPLE_WIDTH-1:0] hi_val;
   logic                    load;

   // Middle positions: equal for an odd window, adjacent for an even one
   always_comb begin
      lo_idx = IDX_WIDTH'((win - CNT_WIDTH'(1)) >> 1);
      hi_idx = IDX_WIDTH'(win >> 1);
   end

   // AND-OR select over the chain
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (lo_idx == IDX_WIDTH'(i)) lo_val = lo_val | cells[i].value;
         if (hi_idx == IDX_WIDTH'(i)) hi_val = hi_val | cells[i].value;
      end
      median_in = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};
   end

   // Output register; a pending result waits while the receiver stalls
   always_comb begin
      hold         = fire && rsp_valid_ff && !rsp_ready;
      load         = fire && !hold;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign median_doubled = median_ff;

endmodule

@@ rtl/sliding_window_median.sv @@
// Top level of the sliding window median filter.
// Depends on swm_pkg, swm_stream_if, swm_cell and swm_median_out.
//
// Usage:
//   req_chan carries one signed sample per beat; rsp_chan returns twice the
//   median of the last csr window samples (sum of the two middle values for
//   an even window). csr_wr_en/csr_wr_data load the window length; zero acts
//   as 1 and values above 32 act as 32. Write it only while the block is idle.
//   No result is returned while the window holds fewer samples than its
//   length; once it is full each sample yields exactly one result beat.
// Throughput: one sample per cycle in steady state with no stalled result.
//   The sorted chain of 32 cells removes one stale entry per update, so after
//   a shortening the first sample waits until the extra stale ones are gone.
// Pipeline: a sample beat updates the chain registers; the middle cells are
//   then selected, added and loaded into the output register.
// Reset: synchronous, active high; empties the window, clears the result
//   valid flag and sets the window length to 3.
// Stall: a finished result sits in the output register while rsp_chan.ready
//   is low; at most one more sample is taken, then req_chan.ready drops until
//   the result beat is taken.
`timescale 1ns / 1ps

module sliding_window_median import swm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   swm_req_if.sink              req_chan,
   swm_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_WIDTH-1:0] csr_wr_data
);

   logic [CSR_WIDTH-1:0] window_ff;
   logic [CNT_WIDTH-1:0] fill_ff;
   logic [CNT_WIDTH-1:0] fill_in;
   logic                 fire_ff;
   logic                 fire_in;

   cell_ctrl_type        ctrl;
   cell_type             cell_q     [MAX_WINDOW];
   cell_type             left_cell  [MAX_WINDOW];
   cell_type             right_cell [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] le;
   logic [MAX_WINDOW-1:0] evict;
   logic [MAX_WINDOW-1:0] past;
   logic [MAX_WINDOW-1:0] left_le;
   logic [MAX_WINDOW-1:0] left_past;
   logic [MAX_WINDOW-1:0] right_le;

   logic                 hold;
   logic                 multi_evict;
   logic                 any_evict;
   logic                 accept;
   logic                 step;

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Handshake and chain control
   // extra stale entries are dropped only while a sample beat waits
   always_comb begin
      any_evict      = past[MAX_WINDOW-1];
      multi_evict    = |(evict & (evict - MAX_WINDOW'(1)));
      req_chan.ready = !hold && !multi_evict;
      accept         = req_chan.valid && req_chan.ready;
      step           = !hold && (accept || (multi_evict && req_chan.valid));
      ctrl.step      = step;
      ctrl.ins       = accept;
      ctrl.sample    = req_chan.sample;
      ctrl.win       = eff_window(window_ff);
   end

   // Occupancy: per update, at most one stale entry out and any accepted sample in
   always_comb begin
      fill_in = fill_ff;
      if (step) begin
         fill_in = fill_ff - CNT_WIDTH'(step && any_evict) + CNT_WIDTH'(accept);
      end
      fire_in = hold ? fire_ff : (accept && (fill_in == ctrl.win));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fire_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         fire_ff <= fire_in;
      end
   end

   // Neighbor wiring; the ends see an empty slot
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_link
      if (i == 0) begin : g_first
         assign left_cell[i] = '0;
         assign left_le[i]   = 1'b1;
         assign left_past[i] = 1'b0;
      end else begin : g_inner_l
         assign left_cell[i] = cell_q[i-1];
         assign left_le[i]   = le[i-1];
         assign left_past[i] = past[i-1];
      end
      if (i == MAX_WINDOW - 1) begin : g_last
         assign right_cell[i] = '0;
         assign right_le[i]   = 1'b0;
      end else begin : g_inner_r
         assign right_cell[i] = cell_q[i+1];
         assign right_le[i]   = le[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_cell  (left_cell[i]),
         .left_le    (left_le[i]),
         .left_past  (left_past[i]),
         .right_cell (right_cell[i]),
         .right_le   (right_le[i]),
         .cell_q     (cell_q[i]),
         .le         (le[i]),
         .evict      (evict[i]),
         .past       (past[i])
      );
   end

   // Middle select, add and output register
   swm_median_out u_out (
      .clock          (clock),
      .reset          (reset),
      .cells          (cell_q),
      .win            (ctrl.win),
      .fire           (fire_ff),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .median_doubled (rsp_chan.median_doubled),
      .hold           (hold)
   );

endmodule

@@ rtl/swm_checker.sv @@
// Port-level checks for the sliding window median top level, bound to it.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_WIDTH-1:0] rsp_median
);

   // Reset clears the result valid flag
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // A stalled result beat stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("stalled result beat changed");

   // A rising result valid follows an accepted sample beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without matching sample beat");

   // While a result is stalled, at most one sample is taken before ready drops
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && req_valid && req_ready ##1
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("sample beat taken with result path blocked");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_median (rsp_chan.median_doubled)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for sliding_window_median: drives sample beats and window writes,
// predicts twice the running median and compares every result beat against it.
// Depends on swm_pkg, swm_stream_if and the sliding_window_median RTL.
`timescale 1ns / 1ps

module tb_top;
   import swm_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] S_MAX = ~S_MIN;
   localparam int STALL_LIMIT = 4000;   // cycles with no beat on either channel
   localparam int SETTLE_CYCLES = 8;    // covers the pipeline tail plus stale eviction

   // Window predictor and queue of pending doubled medians
   class median_board;
      typedef struct {
         logic signed [SAMPLE_WIDTH-1:0] value;
         int                             age;
      } slot_type;

      slot_type             chain[$];     // window contents, ascending by value
      logic [CSR_WIDTH-1:0] window_raw;
      logic [OUT_WIDTH-1:0] medians[$];
      int                   errors;

      function new();
         window_raw = WINDOW_RESET;
         errors = 0;
      endfunction

      function void set_window(logic [CSR_WIDTH-1:0] raw);
         window_raw = raw;
      endfunction

      function int pending();
         return medians.size();
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      // Accepted sample beat: age out stale cells, insert in order, maybe emit
      function void note_sample(logic signed [SAMPLE_WIDTH-1:0] s);
         slot_type kept[$];
         int       w;
         int       pos;
         longint   total;
         w = (window_raw == 0) ? 1 : (int'(window_raw) > MAX_WINDOW) ? MAX_WINDOW
                                                                      : int'(window_raw);
         foreach (chain[i]) begin
            if (chain[i].age + 1 < w) begin
               kept.insert(kept.size(), '{chain[i].value, chain[i].age + 1});
            end
         end
         pos = 0;
         while (pos < kept.size() && kept[pos].value <= s) pos++;
         kept.insert(pos, '{s, 0});
         chain = kept;
         if (chain.size() == w) begin
            if (w % 2 == 1) begin
               total = 2 * longint'(chain[w / 2].value);
            end else begin
               total = longint'(chain[w / 2 - 1].value) + longint'(chain[w / 2].value);
            end
            medians.insert(medians.size(), total[OUT_WIDTH-1:0]);
         end
      endfunction

      // Result beat against the oldest prediction
      task check_median(logic [OUT_WIDTH-1:0] got);
         logic [OUT_WIDTH-1:0] want;
         if (medians.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", $signed(got)));
         end else begin
            want = medians.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("median_doubled %0d, predicted %0d",
                                         $signed(got), $signed(want)));
            end
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_WIDTH-1:0] csr_wr_data;
   logic                 no_idle;
   int                   quiet_cycles;
   median_board          board = new();

   swm_req_if sample_bus ();
   swm_rsp_if median_bus ();

   sliding_window_median u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (sample_bus),
      .rsp_chan    (median_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         median_bus.ready <= 1'b0;
      end else begin
         median_bus.ready <= no_idle || ($urandom_range(0, 99) >= 35);
      end
   end

   // Monitor: check result beats first, then feed the accepted sample
   always @(posedge clock) begin
      if (!reset) begin
         if (median_bus.valid && median_bus.ready) board.check_median(median_bus.median_doubled);
         if (sample_bus.valid && sample_bus.ready) board.note_sample(sample_bus.sample);
      end
   end

   // Watchdog on channel activity
   always @(posedge clock) begin
      if (reset || (sample_bus.valid && sample_bus.ready) ||
          (median_bus.valid && median_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // One sample beat, with random gaps ahead of it; returns at the accepting edge
   task send_sample(logic [SAMPLE_WIDTH-1:0] value);
      while (!no_idle && $urandom_range(0, 99) < 35) begin
         sample_bus.valid <= 1'b0;
         @(posedge clock);
      end
      sample_bus.valid  <= 1'b1;
      sample_bus.sample <= value;
      @(posedge clock);
      while (!sample_bus.ready) @(posedge clock);
   endtask

   // Drop valid and wait for every predicted result plus the pipeline tail
   task drain;
      sample_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Window register write, only with the block idle
   task write_window(logic [CSR_WIDTH-1:0] raw);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      board.set_window(raw);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Random sample: wide values, clustered small values for ties, extremes, repeats
   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(logic [SAMPLE_WIDTH-1:0] last);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return $urandom;
      if (roll < 75) return SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
      if (roll < 90) begin
         case ($urandom_range(0, 5))
            0: return S_MIN;
            1: return S_MAX;
            2: return S_MIN + 1;
            3: return S_MAX - 1;
            4: return '0;
            default: return '1;
         endcase
      end
      return last;
   endfunction

   // Stimulus
   initial begin
      logic [SAMPLE_WIDTH-1:0] corner_samples [0:19];
      logic [CSR_WIDTH-1:0]    windows [0:11];
      logic [SAMPLE_WIDTH-1:0] last;

      // extremes, mixed signs and runs of equal values at the reset window of 3
      corner_samples = '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, '0,
                         SAMPLE_WIDTH'(-1), SAMPLE_WIDTH'(1), SAMPLE_WIDTH'(7),
                         SAMPLE_WIDTH'(7), SAMPLE_WIDTH'(7), SAMPLE_WIDTH'(7),
                         SAMPLE_WIDTH'(-5), SAMPLE_WIDTH'(3), S_MAX, S_MIN, '0};
      // zero acts as one, above 32 saturates, shrinking keeps contents and evicts stale cells
      windows = '{CSR_WIDTH'(1), CSR_WIDTH'(0), CSR_WIDTH'(2), CSR_WIDTH'(32),
                  CSR_WIDTH'(63), CSR_WIDTH'(33), CSR_WIDTH'(6), CSR_WIDTH'(31),
                  CSR_WIDTH'(4), CSR_WIDTH'(17), CSR_WIDTH'(7), CSR_WIDTH'(0)};
      windows[11] = CSR_WIDTH'($urandom_range(0, 63));

      reset             = 1'b1;
      no_idle           = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      sample_bus.valid  = 1'b0;
      sample_bus.sample = '0;
      last              = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_samples[i]) send_sample(corner_samples[i]);

      foreach (windows[p]) begin
         write_window(windows[p]);
         no_idle = (p == 4);   // one long burst with neither side idling
         repeat (95) begin
            last = pick_sample(last);
            send_sample(last);
         end
         no_idle = 1'b0;
      end

      drain();
      if (board.pending() != 0) begin
         board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
      end
      if (board.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
